// ===== design/g2p_pkg.sv =====
// shared widths and beat types for the grid-to-particle flip gather unit
package g2p_pkg;

  localparam int VAL_W  = 32;
  localparam int WGT_W  = 17;
  localparam int MM_W   = 16;
  localparam int GACC_W = 64;
  // rounded product widths, sized for the narrowest fraction (8 bits)
  localparam int WRND_W = 42;
  localparam int GRND_W = 56;
  // common width for saturating sums and clamps
  localparam int SUM_W  = 66;

  typedef struct packed {
    logic                    first_node;
    logic                    last_node;
    logic signed [VAL_W-1:0] particle_vx;
    logic signed [VAL_W-1:0] particle_vy;
    logic signed [VAL_W-1:0] node_new_vx;
    logic signed [VAL_W-1:0] node_new_vy;
    logic signed [VAL_W-1:0] node_old_vx;
    logic signed [VAL_W-1:0] node_old_vy;
    logic signed [VAL_W-1:0] node_heat;
    logic        [WGT_W-1:0] weight;
    logic signed [VAL_W-1:0] wgrad_x;
    logic signed [VAL_W-1:0] wgrad_y;
  } node_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_vx;
    logic signed [VAL_W-1:0] out_vy;
    logic signed [VAL_W-1:0] grad_xx;
    logic signed [VAL_W-1:0] grad_xy;
    logic signed [VAL_W-1:0] grad_yx;
    logic signed [VAL_W-1:0] grad_yy;
    logic signed [VAL_W-1:0] out_heat;
    logic signed [MM_W-1:0]  heat_min;
    logic signed [MM_W-1:0]  heat_max;
  } result_t;

  typedef struct packed {
    logic                     first_node;
    logic                     last_node;
    logic signed [VAL_W-1:0]  particle_vx;
    logic signed [VAL_W-1:0]  particle_vy;
    logic signed [WRND_W-1:0] pic_x;
    logic signed [WRND_W-1:0] pic_y;
    logic signed [WRND_W-1:0] flip_x;
    logic signed [WRND_W-1:0] flip_y;
    logic signed [WRND_W-1:0] heat;
    logic signed [GRND_W-1:0] grad_xx;
    logic signed [GRND_W-1:0] grad_xy;
    logic signed [GRND_W-1:0] grad_yx;
    logic signed [GRND_W-1:0] grad_yy;
  } prod_t;

endpackage

// ===== design/g2p_mult.sv =====
// node product stage: weighted and gradient products, rounded and registered
module g2p_mult import g2p_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  node_valid,
  input  node_t node,
  output logic  prod_valid,
  output prod_t prod
);

  localparam int WP_W = VAL_W + WGT_W + 2;
  localparam int GP_W = 2 * VAL_W;
  localparam logic signed [WP_W-1:0] WHALF = WP_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [GP_W-1:0] GHALF = GP_W'(1) << (FRAC_BITS - 1);

  logic signed [WP_W-1:0] wgt_s;
  logic signed [WP_W-1:0] dvx;
  logic signed [WP_W-1:0] dvy;
  logic signed [WP_W-1:0] p_pic_x;
  logic signed [WP_W-1:0] p_pic_y;
  logic signed [WP_W-1:0] p_flip_x;
  logic signed [WP_W-1:0] p_flip_y;
  logic signed [WP_W-1:0] p_heat;
  logic signed [GP_W-1:0] p_gxx;
  logic signed [GP_W-1:0] p_gxy;
  logic signed [GP_W-1:0] p_gyx;
  logic signed [GP_W-1:0] p_gyy;
  prod_t                  prod_next;

  always_comb begin
    // weight is unsigned, so it enters with a zero sign bit
    wgt_s    = $signed(WP_W'(node.weight));
    dvx      = WP_W'(node.node_new_vx) - WP_W'(node.node_old_vx);
    dvy      = WP_W'(node.node_new_vy) - WP_W'(node.node_old_vy);
    p_pic_x  = WP_W'(node.node_new_vx) * wgt_s;
    p_pic_y  = WP_W'(node.node_new_vy) * wgt_s;
    p_flip_x = dvx * wgt_s;
    p_flip_y = dvy * wgt_s;
    p_heat   = WP_W'(node.node_heat) * wgt_s;
    p_gxx    = GP_W'(node.node_new_vx) * GP_W'(node.wgrad_x);
    p_gxy    = GP_W'(node.node_new_vx) * GP_W'(node.wgrad_y);
    p_gyx    = GP_W'(node.node_new_vy) * GP_W'(node.wgrad_x);
    p_gyy    = GP_W'(node.node_new_vy) * GP_W'(node.wgrad_y);

    prod_next.first_node  = node.first_node;
    prod_next.last_node   = node.last_node;
    prod_next.particle_vx = node.particle_vx;
    prod_next.particle_vy = node.particle_vy;
    // round half up, then drop the fraction
    prod_next.pic_x   = WRND_W'((p_pic_x + WHALF) >>> FRAC_BITS);
    prod_next.pic_y   = WRND_W'((p_pic_y + WHALF) >>> FRAC_BITS);
    prod_next.flip_x  = WRND_W'((p_flip_x + WHALF) >>> FRAC_BITS);
    prod_next.flip_y  = WRND_W'((p_flip_y + WHALF) >>> FRAC_BITS);
    prod_next.heat    = WRND_W'((p_heat + WHALF) >>> FRAC_BITS);
    prod_next.grad_xx = GRND_W'((p_gxx + GHALF) >>> FRAC_BITS);
    prod_next.grad_xy = GRND_W'((p_gxy + GHALF) >>> FRAC_BITS);
    prod_next.grad_yx = GRND_W'((p_gyx + GHALF) >>> FRAC_BITS);
    prod_next.grad_yy = GRND_W'((p_gyy + GHALF) >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= node_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (node_valid) begin
      prod <= prod_next;
    end
  end

endmodule

// ===== design/g2p_accum.sv =====
// saturating accumulators for pic, flip, heat and velocity gradient sums
module g2p_accum import g2p_pkg::*; #(
  parameter int ACC_BITS = 48
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       prod_valid,
  input  prod_t                      prod,
  output logic                       emit_valid,
  output logic signed [ACC_BITS-1:0] pic_x,
  output logic signed [ACC_BITS-1:0] pic_y,
  output logic signed [ACC_BITS-1:0] flip_x,
  output logic signed [ACC_BITS-1:0] flip_y,
  output logic signed [ACC_BITS-1:0] heat,
  output logic signed [GACC_W-1:0]   grad_xx,
  output logic signed [GACC_W-1:0]   grad_xy,
  output logic signed [GACC_W-1:0]   grad_yx,
  output logic signed [GACC_W-1:0]   grad_yy
);

  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [SUM_W-1:0] GACC_MAX =
    {{(SUM_W - GACC_W + 1){1'b0}}, {(GACC_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] GACC_MIN = ~GACC_MAX;

  function automatic logic signed [ACC_BITS-1:0] acc_add(
    input logic signed [ACC_BITS-1:0] base,
    input logic signed [WRND_W-1:0]   inc
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(inc);
    if (s > ACC_MAX) begin
      s = ACC_MAX;
    end else if (s < ACC_MIN) begin
      s = ACC_MIN;
    end
    return ACC_BITS'(s);
  endfunction

  function automatic logic signed [GACC_W-1:0] gacc_add(
    input logic signed [GACC_W-1:0] base,
    input logic signed [GRND_W-1:0] inc
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(inc);
    if (s > GACC_MAX) begin
      s = GACC_MAX;
    end else if (s < GACC_MIN) begin
      s = GACC_MIN;
    end
    return GACC_W'(s);
  endfunction

  logic signed [ACC_BITS-1:0] base_pic_x;
  logic signed [ACC_BITS-1:0] base_pic_y;
  logic signed [ACC_BITS-1:0] base_flip_x;
  logic signed [ACC_BITS-1:0] base_flip_y;
  logic signed [ACC_BITS-1:0] base_heat;
  logic signed [GACC_W-1:0]   base_gxx;
  logic signed [GACC_W-1:0]   base_gxy;
  logic signed [GACC_W-1:0]   base_gyx;
  logic signed [GACC_W-1:0]   base_gyy;

  // first node restarts the sums; flip starts from the particle velocity
  always_comb begin
    base_pic_x  = prod.first_node ? '0 : pic_x;
    base_pic_y  = prod.first_node ? '0 : pic_y;
    base_heat   = prod.first_node ? '0 : heat;
    base_flip_x = prod.first_node ? ACC_BITS'(prod.particle_vx) : flip_x;
    base_flip_y = prod.first_node ? ACC_BITS'(prod.particle_vy) : flip_y;
    base_gxx    = prod.first_node ? '0 : grad_xx;
    base_gxy    = prod.first_node ? '0 : grad_xy;
    base_gyx    = prod.first_node ? '0 : grad_yx;
    base_gyy    = prod.first_node ? '0 : grad_yy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_valid <= 1'b0;
      pic_x      <= '0;
      pic_y      <= '0;
      flip_x     <= '0;
      flip_y     <= '0;
      heat       <= '0;
      grad_xx    <= '0;
      grad_xy    <= '0;
      grad_yx    <= '0;
      grad_yy    <= '0;
    end else begin
      emit_valid <= prod_valid && prod.last_node;
      if (prod_valid) begin
        pic_x   <= acc_add(base_pic_x, prod.pic_x);
        pic_y   <= acc_add(base_pic_y, prod.pic_y);
        flip_x  <= acc_add(base_flip_x, prod.flip_x);
        flip_y  <= acc_add(base_flip_y, prod.flip_y);
        heat    <= acc_add(base_heat, prod.heat);
        grad_xx <= gacc_add(base_gxx, prod.grad_xx);
        grad_xy <= gacc_add(base_gxy, prod.grad_xy);
        grad_yx <= gacc_add(base_gyx, prod.grad_yx);
        grad_yy <= gacc_add(base_gyy, prod.grad_yy);
      end
    end
  end

endmodule

// ===== design/g2p_emit.sv =====
// result stages: pic/flip blend, output saturation and running heat range
module g2p_emit import g2p_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int ACC_BITS  = 48
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       emit_valid,
  input  logic signed [ACC_BITS-1:0] pic_x,
  input  logic signed [ACC_BITS-1:0] pic_y,
  input  logic signed [ACC_BITS-1:0] flip_x,
  input  logic signed [ACC_BITS-1:0] flip_y,
  input  logic signed [ACC_BITS-1:0] heat,
  input  logic signed [GACC_W-1:0]   grad_xx,
  input  logic signed [GACC_W-1:0]   grad_xy,
  input  logic signed [GACC_W-1:0]   grad_yx,
  input  logic signed [GACC_W-1:0]   grad_yy,
  input  logic        [WGT_W-1:0]    flip_fraction,
  output logic                       result_valid,
  output result_t                    result
);

  localparam int FW   = (FRAC_BITS + 1 > WGT_W) ? FRAC_BITS + 1 : WGT_W;
  localparam int BP_W = VAL_W + FW + 1;
  localparam logic [FW-1:0] ONE_F = FW'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] BHALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'(32'h7fff_ffff);
  localparam logic signed [SUM_W-1:0] S32_MIN = ~S32_MAX;
  localparam logic signed [MM_W-1:0] MM_MAX = 16'sh7fff;
  localparam logic signed [MM_W-1:0] MM_MIN = 16'sh8000;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > S32_MAX) begin
      c = S32_MAX;
    end else if (v < S32_MIN) begin
      c = S32_MIN;
    end
    return VAL_W'(c);
  endfunction

  // first result stage
  logic        [FW-1:0]    fc;
  logic        [FW-1:0]    omf;
  logic signed [VAL_W-1:0] fx;
  logic signed [VAL_W-1:0] fy;
  logic signed [VAL_W-1:0] px;
  logic signed [VAL_W-1:0] py;
  logic signed [VAL_W-1:0] h;
  logic signed [VAL_W-1:0] h_fl;
  logic signed [VAL_W-1:0] h_tr;
  logic signed [MM_W-1:0]  h_int;

  logic                    d_valid;
  logic signed [BP_W-1:0]  d_fx;
  logic signed [BP_W-1:0]  d_fy;
  logic signed [BP_W-1:0]  d_px;
  logic signed [BP_W-1:0]  d_py;
  logic signed [VAL_W-1:0] d_gxx;
  logic signed [VAL_W-1:0] d_gxy;
  logic signed [VAL_W-1:0] d_gyx;
  logic signed [VAL_W-1:0] d_gyy;
  logic signed [VAL_W-1:0] d_heat;
  logic signed [MM_W-1:0]  d_hint;

  // second result stage
  logic signed [SUM_W-1:0] bx;
  logic signed [SUM_W-1:0] by;
  logic signed [MM_W-1:0]  running_min;
  logic signed [MM_W-1:0]  running_max;
  logic signed [MM_W-1:0]  running_min_next;
  logic signed [MM_W-1:0]  running_max_next;

  always_comb begin
    fc   = (FW'(flip_fraction) > ONE_F) ? ONE_F : FW'(flip_fraction);
    omf  = ONE_F - fc;
    fx   = sat32(SUM_W'(flip_x));
    fy   = sat32(SUM_W'(flip_y));
    px   = sat32(SUM_W'(pic_x));
    py   = sat32(SUM_W'(pic_y));
    h    = sat32(SUM_W'(heat));
    // integer part truncated toward zero
    h_fl = h >>> FRAC_BITS;
    h_tr = h_fl + $signed({{(VAL_W - 1){1'b0}},
                           (h[VAL_W-1] && (h[FRAC_BITS-1:0] != '0))});
    if (h_tr > VAL_W'(MM_MAX)) begin
      h_int = MM_MAX;
    end else if (h_tr < VAL_W'(MM_MIN)) begin
      h_int = MM_MIN;
    end else begin
      h_int = MM_W'(h_tr);
    end
  end

  always_comb begin
    bx = SUM_W'(d_fx) + SUM_W'(d_px) + BHALF;
    by = SUM_W'(d_fy) + SUM_W'(d_py) + BHALF;
    running_min_next = (d_hint < running_min) ? d_hint : running_min;
    running_max_next = (d_hint > running_max) ? d_hint : running_max;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid      <= 1'b0;
      result_valid <= 1'b0;
      running_min  <= MM_MAX;
      running_max  <= MM_MIN;
    end else begin
      d_valid      <= emit_valid;
      result_valid <= d_valid;
      if (d_valid) begin
        running_min <= running_min_next;
        running_max <= running_max_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      d_fx   <= BP_W'(fx) * BP_W'($signed({1'b0, fc}));
      d_fy   <= BP_W'(fy) * BP_W'($signed({1'b0, fc}));
      d_px   <= BP_W'(px) * BP_W'($signed({1'b0, omf}));
      d_py   <= BP_W'(py) * BP_W'($signed({1'b0, omf}));
      d_gxx  <= sat32(SUM_W'(grad_xx));
      d_gxy  <= sat32(SUM_W'(grad_xy));
      d_gyx  <= sat32(SUM_W'(grad_yx));
      d_gyy  <= sat32(SUM_W'(grad_yy));
      d_heat <= h;
      d_hint <= h_int;
    end
    if (d_valid) begin
      result.out_vx   <= sat32(bx >>> FRAC_BITS);
      result.out_vy   <= sat32(by >>> FRAC_BITS);
      result.grad_xx  <= d_gxx;
      result.grad_xy  <= d_gxy;
      result.grad_yx  <= d_gyx;
      result.grad_yy  <= d_gyy;
      result.out_heat <= d_heat;
      result.heat_min <= running_min_next;
      result.heat_max <= running_max_next;
    end
  end

`ifndef ASSERT_OFF
  a_range_ordered: assert property (@(posedge clk) disable iff (rst)
    d_valid |=> (running_min <= running_max))
    else $error("running heat minimum above maximum after a result");
`endif

endmodule

// ===== design/g2p_fifo.sv =====
// result queue between the result stage and the output channel
module g2p_fifo import g2p_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    valid,
  output result_t data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t           mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ((count != CNT_W'(DEPTH)) || pop))
    else $error("result queue written while full");
`endif

endmodule

// ===== design/grid_to_particle_flip_gather_unit.sv =====
// a last-node beat's result beat passes the input register, the product stage, the accumulators,
// both result stages and the result queue before it is offered; throughput: one node beat per cycle
// while node_stall is low, each node a single pass through the multipliers; results wait in a
// RESULT_DEPTH queue; node beats stall only when that many are owed; reset clears all sums, sets
// flip_fraction to 62259, heat range to empty (min 32767, max -32768); cfg writes are taken every cycle
module grid_to_particle_flip_gather_unit import g2p_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int ACC_BITS     = 48,
  parameter int RESULT_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             node_valid,
  output logic             node_stall,
  input  node_t            node,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [WGT_W-1:0] cfg_data
);

  localparam int PEND_W = $clog2(RESULT_DEPTH + 1);
  localparam logic [WGT_W-1:0] FLIP_FRACTION_RESET = 17'd62259;

  logic              node_accept;
  logic              result_pop;
  logic [WGT_W-1:0]  flip_fraction;
  logic [PEND_W-1:0] pending;

  logic              a_valid;
  node_t             a_node;
  logic              prod_valid;
  prod_t             prod;
  logic              emit_valid;

  logic signed [ACC_BITS-1:0] acc_pic_x;
  logic signed [ACC_BITS-1:0] acc_pic_y;
  logic signed [ACC_BITS-1:0] acc_flip_x;
  logic signed [ACC_BITS-1:0] acc_flip_y;
  logic signed [ACC_BITS-1:0] acc_heat;
  logic signed [GACC_W-1:0]   acc_gxx;
  logic signed [GACC_W-1:0]   acc_gxy;
  logic signed [GACC_W-1:0]   acc_gyx;
  logic signed [GACC_W-1:0]   acc_gyy;

  logic    res_push;
  result_t res_data;

  assign cfg_ready   = 1'b1;
  assign node_accept = node_valid && !node_stall;
  assign result_pop  = result_valid && !result_stall;
  // a queue slot is reserved when a last-node beat is accepted, so the queue cannot overflow
  assign node_stall  = (pending == PEND_W'(RESULT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      flip_fraction <= FLIP_FRACTION_RESET;
      pending       <= '0;
      a_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        flip_fraction <= cfg_data;
      end
      a_valid <= node_accept;
      case ({node_accept && node.last_node, result_pop})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (node_accept) begin
      a_node <= node;
    end
  end

  g2p_mult #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mult (
    .clk        (clk),
    .rst        (rst),
    .node_valid (a_valid),
    .node       (a_node),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  g2p_accum #(
    .ACC_BITS (ACC_BITS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod       (prod),
    .emit_valid (emit_valid),
    .pic_x      (acc_pic_x),
    .pic_y      (acc_pic_y),
    .flip_x     (acc_flip_x),
    .flip_y     (acc_flip_y),
    .heat       (acc_heat),
    .grad_xx    (acc_gxx),
    .grad_xy    (acc_gxy),
    .grad_yx    (acc_gyx),
    .grad_yy    (acc_gyy)
  );

  g2p_emit #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_BITS  (ACC_BITS)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .emit_valid    (emit_valid),
    .pic_x         (acc_pic_x),
    .pic_y         (acc_pic_y),
    .flip_x        (acc_flip_x),
    .flip_y        (acc_flip_y),
    .heat          (acc_heat),
    .grad_xx       (acc_gxx),
    .grad_xy       (acc_gxy),
    .grad_yx       (acc_gyx),
    .grad_yy       (acc_gyy),
    .flip_fraction (flip_fraction),
    .result_valid  (res_push),
    .result        (res_data)
  );

  g2p_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .pop       (result_pop),
    .valid     (result_valid),
    .data      (result)
  );

`ifndef ASSERT_OFF
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(RESULT_DEPTH))
    else $error("more results owed than queue slots");
  a_result_owed: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pending != '0))
    else $error("result beat offered with none owed");
`endif

endmodule
